[rtl/core/oaht_pkg.sv]
// Package for the open-addressing hash table: payload types, codes, states and reset values.
`default_nettype none

package oaht_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int KEY_W     = 31;
    localparam int SLOT_W    = 6;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST   = 7'd10;
    localparam logic             PROBE_MODE_RST   = 1'b0;
    localparam logic [CFG_W-1:0] STEP_MODULUS_RST = 7'd11;
    localparam logic [31:0]      EMPTY_MARKER_RST = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_TABLE_SIZE   = 2'd0,
        REG_PROBE_MODE   = 2'd1,
        REG_STEP_MODULUS = 2'd2,
        REG_EMPTY_MARKER = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_DOUBLE = 1'b1
    } t_probe_mode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_STEPM,
        S_STEPN,
        S_READ,
        S_CMP
    } t_state;

    typedef struct packed {
        t_opcode          opcode;
        logic [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } t_out;

endpackage

`default_nettype wire

[rtl/core/oaht_rem.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module oaht_rem #(
    parameter int DW = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [oaht_pkg::KEY_W-1:0] i_dividend,
    input  wire logic [DW-1:0]             i_divisor,
    output logic                           o_done,
    output logic [DW-1:0]                  o_rem
);

    localparam int CW = $clog2(oaht_pkg::KEY_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [DW-1:0]               r_rem;
    logic [DW-1:0]               r_div;
    logic [oaht_pkg::KEY_W-1:0]  r_dvd;
    logic [DW:0]                 trial;
    logic [DW:0]                 diff;
    logic [DW-1:0]               n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[oaht_pkg::KEY_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[DW-1:0];
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(oaht_pkg::KEY_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[oaht_pkg::KEY_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[rtl/core/open_addressing_hash_table_unit.sv]
// Top level of the open-addressing hash table: APB registers, sequencer and slot memory.
//
// Channel   Signals                         Direction  Transfer
// command   start, busy, i_cmd              in         start high while busy low
// result    o_done, o_result                out        one cycle, o_done high
// config    psel..pwdata, prdata, pready    in/out     APB, pready always high
//
// An item finds the home index (key mod table size clamped to 1..SLOTS, one bit a cycle
// in the shared remainder unit), in double hashing mode then the step in that unit, then
// does a registered memory read and a compare per probe, for up to the clamped size in
// probes. After reset a clearing pass writes the reset empty marker to all SLOTS entries,
// one a cycle, with busy high. The result strobe cannot be held off.
`default_nettype none

module open_addressing_hash_table_unit #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire oaht_pkg::t_in i_cmd,
    output logic               o_done,
    output oaht_pkg::t_out     o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int DW = (NW > oaht_pkg::CFG_W) ? NW : oaht_pkg::CFG_W;

    // configuration
    logic [oaht_pkg::CFG_W-1:0] r_table_size;
    logic                       r_probe_mode;
    logic [oaht_pkg::CFG_W-1:0] r_step_modulus;
    logic [31:0]                r_empty_marker;
    oaht_pkg::t_reg_idx         reg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = oaht_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size   <= oaht_pkg::TABLE_SIZE_RST;
            r_probe_mode   <= oaht_pkg::PROBE_MODE_RST;
            r_step_modulus <= oaht_pkg::STEP_MODULUS_RST;
            r_empty_marker <= oaht_pkg::EMPTY_MARKER_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                oaht_pkg::REG_TABLE_SIZE:   r_table_size   <= pwdata[oaht_pkg::CFG_W-1:0];
                oaht_pkg::REG_PROBE_MODE:   r_probe_mode   <= pwdata[0];
                oaht_pkg::REG_STEP_MODULUS: r_step_modulus <= pwdata[oaht_pkg::CFG_W-1:0];
                oaht_pkg::REG_EMPTY_MARKER: r_empty_marker <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            oaht_pkg::REG_TABLE_SIZE:   prdata = 32'(r_table_size);
            oaht_pkg::REG_PROBE_MODE:   prdata = 32'(r_probe_mode);
            oaht_pkg::REG_STEP_MODULUS: prdata = 32'(r_step_modulus);
            oaht_pkg::REG_EMPTY_MARKER: prdata = r_empty_marker;
            default:                    prdata = '0;
        endcase
    end

    // effective size and step modulus
    logic [NW-1:0]              eff_n;
    logic [31:0]                ts_ext;
    logic [oaht_pkg::CFG_W-1:0] eff_m;

    always_comb begin
        ts_ext = 32'(r_table_size);
        if (ts_ext == 32'd0) begin
            eff_n = NW'(1);
        end else if (ts_ext > 32'(SLOTS)) begin
            eff_n = NW'(SLOTS);
        end else begin
            eff_n = ts_ext[NW-1:0];
        end
        eff_m = (r_step_modulus == '0) ? oaht_pkg::CFG_W'(1) : r_step_modulus;
    end

    // item registers and sequencer
    oaht_pkg::t_state           r_state, n_state;
    oaht_pkg::t_opcode          r_op;
    logic [oaht_pkg::KEY_W-1:0] r_key;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              r_step;
    logic [NW-1:0]              r_cnt;
    logic [AW-1:0]              r_clr;
    logic                       r_done;
    logic                       r_ok;
    logic [oaht_pkg::SLOT_W-1:0] r_slot;

    logic                       accept;
    logic                       div_start;
    logic [oaht_pkg::KEY_W-1:0] div_dividend;
    logic [DW-1:0]              div_divisor;
    logic                       div_done;
    logic [DW-1:0]              div_rem;

    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic [31:0]                mem_wdata;
    logic [31:0]                r_rdata;
    logic [31:0]                mem [SLOTS];

    logic                       is_empty;
    logic                       is_key;
    logic                       hit;
    logic                       finish;
    logic                       last_probe;
    logic [NW-1:0]              cnt_inc;
    logic [AW:0]                idx_sum;
    logic [AW:0]                idx_wrap;
    logic [AW-1:0]              idx_next;
    logic [7:0]                 step_plus;
    logic [AW-1:0]              lin_step;
    logic [31:0]                idx_ext;

    assign busy   = (r_state != oaht_pkg::S_IDLE);
    assign accept = start & ~busy;

    always_comb begin
        is_empty   = (r_rdata == r_empty_marker);
        is_key     = (r_rdata == {1'b0, r_key});
        hit        = (r_op == oaht_pkg::OP_INSERT) ? is_empty : is_key;
        cnt_inc    = r_cnt + 1'b1;
        last_probe = (cnt_inc == eff_n);
        // a search stops at the first free slot once the key test has failed
        finish     = hit | (r_op == oaht_pkg::OP_SEARCH && is_empty) | last_probe;
        idx_sum    = {1'b0, r_idx} + {1'b0, r_step};
        idx_wrap   = idx_sum - (AW + 1)'(eff_n);
        idx_next   = (32'(idx_sum) >= 32'(eff_n)) ? idx_wrap[AW-1:0] : idx_sum[AW-1:0];
        step_plus  = {1'b0, div_rem[oaht_pkg::CFG_W-1:0]} + 8'd1;
        lin_step   = (eff_n == NW'(1)) ? AW'(0) : AW'(1);
        idx_ext    = 32'(r_idx);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            oaht_pkg::S_CLEAR: if (r_clr == AW'(SLOTS - 1)) n_state = oaht_pkg::S_IDLE;
            oaht_pkg::S_IDLE:  if (accept) n_state = oaht_pkg::S_HOME;
            oaht_pkg::S_HOME: begin
                if (div_done) begin
                    n_state = (r_probe_mode == oaht_pkg::MODE_DOUBLE) ? oaht_pkg::S_STEPM
                                                                      : oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_STEPM: if (div_done) n_state = oaht_pkg::S_STEPN;
            oaht_pkg::S_STEPN: if (div_done) n_state = oaht_pkg::S_READ;
            oaht_pkg::S_READ:  n_state = oaht_pkg::S_CMP;
            oaht_pkg::S_CMP:   n_state = finish ? oaht_pkg::S_IDLE : oaht_pkg::S_READ;
            default:           n_state = oaht_pkg::S_IDLE;
        endcase
    end

    // remainder unit and memory control
    always_comb begin
        div_start    = 1'b0;
        div_dividend = i_cmd.key;
        div_divisor  = DW'(eff_n);
        mem_we       = 1'b0;
        mem_addr     = r_idx;
        mem_wdata    = {1'b0, r_key};
        case (r_state)
            oaht_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = oaht_pkg::EMPTY_MARKER_RST;
            end
            oaht_pkg::S_IDLE: div_start = accept;
            oaht_pkg::S_HOME: begin
                div_start    = div_done && (r_probe_mode == oaht_pkg::MODE_DOUBLE);
                div_dividend = r_key;
                div_divisor  = DW'(eff_m);
            end
            oaht_pkg::S_STEPM: begin
                div_start    = div_done;
                div_dividend = oaht_pkg::KEY_W'(step_plus);
            end
            oaht_pkg::S_CMP: mem_we = (r_op == oaht_pkg::OP_INSERT) && is_empty;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oaht_pkg::S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (r_state == oaht_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == oaht_pkg::S_CMP && finish) r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_cmd.opcode;
            r_key <= i_cmd.key;
            r_cnt <= '0;
        end
        case (r_state)
            oaht_pkg::S_HOME: begin
                if (div_done) begin
                    r_idx  <= div_rem[AW-1:0];
                    r_step <= lin_step;
                end
            end
            oaht_pkg::S_STEPN: if (div_done) r_step <= div_rem[AW-1:0];
            oaht_pkg::S_CMP: begin
                r_cnt <= cnt_inc;
                if (finish) begin
                    r_ok   <= hit;
                    r_slot <= hit ? idx_ext[oaht_pkg::SLOT_W-1:0] : '0;
                end else begin
                    r_idx <= idx_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    oaht_rem #(
        .DW(DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_done   = r_done;
    assign o_result = '{ok: r_ok, slot: r_slot};

endmodule

`default_nettype wire
